// ===== design/ehp_pkg.sv =====
// Shared types and constants of the Ethernet / IPv4 / layer-4 header parser.
`timescale 1ns / 1ps
package ehp_pkg;

	localparam logic [6:0] POS_MAX       = 7'd127;
	localparam logic [6:0] POS_KIND_HI   = 7'd12;
	localparam logic [6:0] POS_KIND_LO   = 7'd13;
	localparam logic [6:0] POS_IHL       = 7'd14;
	localparam logic [6:0] POS_TLEN_HI   = 7'd16;
	localparam logic [6:0] POS_TLEN_LO   = 7'd17;
	localparam logic [6:0] POS_IDENT_HI  = 7'd18;
	localparam logic [6:0] POS_IDENT_LO  = 7'd19;
	localparam logic [6:0] POS_FRAG_HI   = 7'd20;
	localparam logic [6:0] POS_FRAG_LO   = 7'd21;
	localparam logic [6:0] POS_PROTO     = 7'd23;

	localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
	localparam logic [7:0] IP_HDR_END    = 8'd34;
	localparam logic [7:0] L4_SEQ_OFF    = 8'd4;
	localparam logic [7:0] L4_ACK_OFF    = 8'd8;
	localparam logic [7:0] L4_ACK_END    = 8'd12;
	localparam logic [7:0] L4_FLAGS_OFF  = 8'd13;

	localparam logic [15:0] TYPE_IPV4    = 16'h0800;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [15:0] HTTP_PORT_RST = 16'd80;

	localparam int FLAG_ETHER = 0;
	localparam int FLAG_IPV4  = 1;
	localparam int FLAG_TCP   = 2;
	localparam int FLAG_UDP   = 3;
	localparam int FLAG_HTTP  = 4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRUNC_ETH = 2'd1,
		ST_TRUNC_IP  = 2'd2
	} status_t;

	// Header fields captured so far in the current frame.
	typedef struct packed {
		logic [3:0]  ihl;
		logic [15:0] kind;
		logic [15:0] total_len;
		logic [15:0] ident;
		logic [15:0] frag;
		logic [7:0]  proto;
		logic [31:0] port_pair;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0]  tcp_flags;
	} frame_fields_t;

	// One parse result as it leaves the block.
	typedef struct packed {
		logic [4:0]  layer_flags;
		status_t     status;
		logic [15:0] ether_kind;
		logic [15:0] ip_total_len;
		logic [15:0] ip_ident;
		logic [15:0] ip_frag_word;
		logic [7:0]  ip_proto;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] tcp_seq_num;
		logic [31:0] tcp_ack_num;
		logic [7:0]  tcp_flag_bits;
	} parse_result_t;

endpackage

// ===== design/ehp_capture.sv =====
// Byte position counter and header field capture registers.
`timescale 1ns / 1ps
module ehp_capture import ehp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [7:0]    data_byte,
	input  logic          last,
	output logic [6:0]    pos,
	output frame_fields_t view
);

	logic [6:0]    pos_q;
	frame_fields_t fr_q;
	logic [7:0]    l4_start;
	logic [7:0]    l4_off;

	// The view already holds the current byte, so a field completed by the
	// final byte of a frame is seen by the result logic in the same cycle.
	always_comb begin
		view     = fr_q;
		l4_start = '0;
		l4_off   = '0;
		if (pos_q != POS_MAX) begin
			case (pos_q)
				POS_KIND_HI:  view.kind[15:8]      = data_byte;
				POS_KIND_LO:  view.kind[7:0]       = data_byte;
				POS_IHL:      view.ihl             = data_byte[3:0];
				POS_TLEN_HI:  view.total_len[15:8] = data_byte;
				POS_TLEN_LO:  view.total_len[7:0]  = data_byte;
				POS_IDENT_HI: view.ident[15:8]     = data_byte;
				POS_IDENT_LO: view.ident[7:0]      = data_byte;
				POS_FRAG_HI:  view.frag[15:8]      = data_byte;
				POS_FRAG_LO:  view.frag[7:0]       = data_byte;
				POS_PROTO:    view.proto           = data_byte;
				default: ;
			endcase
			// The layer-4 header starts after the IHL word count, which may
			// have been written by this very byte.
			l4_start = ETH_HDR_BYTES + {2'b00, view.ihl, 2'b00};
			l4_off   = {1'b0, pos_q} - l4_start;
			if ({1'b0, pos_q} >= l4_start) begin
				if (l4_off < L4_SEQ_OFF) begin
					view.port_pair[{~l4_off[1:0], 3'b000} +: 8] = data_byte;
				end else if (l4_off < L4_ACK_OFF) begin
					view.seq[{~l4_off[1:0], 3'b000} +: 8] = data_byte;
				end else if (l4_off < L4_ACK_END) begin
					view.ack[{~l4_off[1:0], 3'b000} +: 8] = data_byte;
				end else if (l4_off == L4_FLAGS_OFF) begin
					view.tcp_flags = data_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fr_q  <= '0;
		end else if (en) begin
			if (last) begin
				pos_q <= '0;
				fr_q  <= '0;
			end else begin
				fr_q <= view;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
			end
		end
	end

	assign pos = pos_q;

endmodule

// ===== design/ehp_result.sv =====
// Layer decision, truncation status and field selection for a finished frame.
`timescale 1ns / 1ps
module ehp_result import ehp_pkg::*; (
	input  logic          [6:0]  pos,
	input  frame_fields_t        view,
	input  logic          [15:0] http_port,
	output parse_result_t        result
);

	logic [7:0]  frame_len;
	logic [15:0] sp;
	logic [15:0] dp;

	assign frame_len = {1'b0, pos} + 8'd1;
	assign sp        = view.port_pair[31:16];
	assign dp        = view.port_pair[15:0];

	always_comb begin
		result        = '0;
		result.status = ST_OK;
		if (frame_len < ETH_HDR_BYTES) begin
			result.status = ST_TRUNC_ETH;
		end else begin
			result.layer_flags[FLAG_ETHER] = 1'b1;
			result.ether_kind              = view.kind;
			if (view.kind == TYPE_IPV4) begin
				result.layer_flags[FLAG_IPV4] = 1'b1;
				if (frame_len < IP_HDR_END) begin
					result.status = ST_TRUNC_IP;
				end else begin
					result.ip_total_len = view.total_len;
					result.ip_ident     = view.ident;
					result.ip_frag_word = view.frag;
					result.ip_proto     = view.proto;
					if (view.proto == PROTO_TCP) begin
						result.layer_flags[FLAG_TCP]  = 1'b1;
						result.layer_flags[FLAG_HTTP] = (sp == http_port) || (dp == http_port);
						result.src_port      = sp;
						result.dst_port      = dp;
						result.tcp_seq_num   = view.seq;
						result.tcp_ack_num   = view.ack;
						result.tcp_flag_bits = view.tcp_flags;
					end else if (view.proto == PROTO_UDP) begin
						result.layer_flags[FLAG_UDP] = 1'b1;
						result.src_port = sp;
						result.dst_port = dp;
					end
				end
			end
		end
	end

endmodule

// ===== design/eth_ipv4_l4_header_parser.sv =====
// Top level of the Ethernet / IPv4 / TCP / UDP header parser.
`timescale 1ns / 1ps
// The parser takes a frame one byte per transaction on the slave stream,
// beginning with the destination MAC, with tlast on the final byte. It
// extracts the Ethernet type, the IPv4 total length, identification,
// fragment word and protocol, skips IPv4 options by the IHL count, and takes
// the TCP ports, sequence, acknowledgement and flag byte, or the UDP ports.
// Exactly one result transaction leaves the master stream per frame, after
// the last byte: tuser carries the layer flags and the truncation status,
// tdata the fields. Fields that were not received, or that do not apply to
// the layers found, read zero. The block takes one byte every cycle unless
// the input is held, also across frame boundaries; a byte passes an input
// register, then the combinational field capture and layer decision, and a
// finished frame's result is registered in the output register. A result
// waiting in the output register does not stop bytes of the next frame;
// only a second last byte meeting a full, stalled output register holds
// the input. The HTTP port register resets to 80 and must only be written
// while idle.
module eth_ipv4_l4_header_parser import ehp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: HTTP port.
	input  logic         http_port_we,
	input  logic [15:0]  http_port_wdata,
	// Slave stream. tdata: data_byte [7:0].
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         s_axis_tlast,
	// Master stream.
	// tdata: ether_kind [15:0], ip_total_len [31:16], ip_ident [47:32],
	//   ip_frag_word [63:48], ip_proto [71:64], src_port [87:72],
	//   dst_port [103:88], tcp_seq_num [135:104], tcp_ack_num [167:136],
	//   tcp_flag_bits [175:168].
	// tuser: layer_flags [4:0], status [6:5].
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [175:0] m_axis_tdata,
	output logic [6:0]   m_axis_tuser
);

	logic          [15:0] http_port_q;
	logic                 valid_s1;
	logic          [7:0]  byte_s1;
	logic                 last_s1;
	logic                 proc_s1;
	logic                 out_valid_q;
	parse_result_t        out_q;
	logic          [6:0]  pos;
	frame_fields_t        view;
	parse_result_t        result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			http_port_q <= HTTP_PORT_RST;
		end else if (http_port_we) begin
			http_port_q <= http_port_wdata;
		end
	end

	// A byte in the input register moves on unless it ends a frame while the
	// previous result is still held by the downstream side.
	assign proc_s1       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || proc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ehp_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (proc_s1),
		.data_byte (byte_s1),
		.last      (last_s1),
		.pos       (pos),
		.view      (view)
	);

	ehp_result u_result (
		.pos       (pos),
		.view      (view),
		.http_port (http_port_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && last_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {out_q.status, out_q.layer_flags};
	assign m_axis_tdata  = {out_q.tcp_flag_bits, out_q.tcp_ack_num, out_q.tcp_seq_num,
		out_q.dst_port, out_q.src_port, out_q.ip_proto, out_q.ip_frag_word,
		out_q.ip_ident, out_q.ip_total_len, out_q.ether_kind};

	// A result only appears after a last byte was processed.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(proc_s1 && last_s1))
		else $error("result appeared without a processed last byte");

	// The frame state starts over after each last byte.
	a_pos_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 && last_s1 |=> pos == 7'd0)
		else $error("byte position not cleared after frame end");

	// A short Ethernet frame reports no layer at all.
	a_trunc_eth_no_layers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_TRUNC_ETH |-> out_q.layer_flags == 5'd0)
		else $error("layer flags set on a truncated Ethernet frame");

	// TCP and UDP exclude each other, and the HTTP match needs TCP.
	a_l4_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.layer_flags[FLAG_TCP] && out_q.layer_flags[FLAG_UDP])
			&& (!out_q.layer_flags[FLAG_HTTP] || out_q.layer_flags[FLAG_TCP]))
		else $error("inconsistent layer-4 flags");

	// The input is never held while the output register can take a result.
	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with an empty output register");

endmodule
